@@ hdl/fqbb_pkg.sv @@
// Shared codes and defaults for the frame queue with byte budget.
// Used by frame_queue_byte_budget and its testbench; depends on nothing else.
package fqbb_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int LEN_BITS_DEF = 20;

	localparam int LIM_W   = 20;  // byte limit and 20-bit payload fields
	localparam int FRAME_W = 5;   // frame limit and frames_held
	localparam int STAT_W  = 3;
	localparam int OP_W    = 2;
	localparam int CFG_W   = 1;

	localparam logic [FRAME_W-1:0] FRAME_LIMIT_RST = FRAME_W'(16);
	localparam logic [LIM_W-1:0]   BYTE_LIMIT_RST  = LIM_W'(65536);

	typedef enum logic [OP_W-1:0] {
		OP_ENQUEUE = 2'd0,
		OP_CONSUME = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK          = 3'd0,
		STAT_INVALID     = 3'd1,
		STAT_TOO_LARGE   = 3'd2,
		STAT_OVERFLOW    = 3'd3,
		STAT_CONSUME_REJ = 3'd4
	} status_t;

	typedef enum logic [CFG_W-1:0] {
		REG_FRAME_LIMIT = 1'b0,
		REG_BYTE_LIMIT  = 1'b1
	} reg_idx_t;

endpackage

@@ hdl/frame_queue_byte_budget.sv @@
// Frame descriptor queue bounded by a frame count and a byte budget.
// Frame lengths live in a ring memory; codes and defaults come from fqbb_pkg.
//
//   channel   direction  handshake              payload
//   request   in         in_valid / in_stall    operation, frame_length, consume_count
//   result    out        out_valid / out_stall  status, frames_held, bytes_held,
//                                               front_remaining, front_popped
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request is taken in ST_IDLE; a consume that pops the front frame while other frames
// remain also passes through ST_FETCH, since the next front length comes from the ring
// memory's registered read port. The front length is cached in a register otherwise.
// Results sit in an output register; a stalled result holds off the next request.
// Reset empties the queue and loads frame_limit 16, byte_limit 65536; no clearing pass.
module frame_queue_byte_budget
	import fqbb_pkg::*;
#(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [OP_W-1:0]    operation,
	input  logic [LIM_W-1:0]   frame_length,
	input  logic [LIM_W-1:0]   consume_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [STAT_W-1:0]  status,
	output logic [FRAME_W-1:0] frames_held,
	output logic [LIM_W-1:0]   bytes_held,
	output logic [LIM_W-1:0]   front_remaining,
	output logic               front_popped,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_W-1:0]   cfg_index,
	input  logic [LIM_W-1:0]   cfg_data
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);
	localparam int CMPW = (CNTW > FRAME_W) ? CNTW : FRAME_W;
	localparam int CW   = (LEN_BITS > LIM_W) ? LEN_BITS : LIM_W;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_FETCH = 2'b10
	} state_t;

	state_t               state_q;
	logic [FRAME_W-1:0]   frame_limit_q;
	logic [LIM_W-1:0]     byte_limit_q;

	logic [LEN_BITS-1:0]  ring_q [DEPTH];
	logic [LEN_BITS-1:0]  rd_data_q;
	logic [AW-1:0]        head_q, tail_q;
	logic [CNTW-1:0]      count_q;
	logic [LEN_BITS-1:0]  offset_q, total_q, front_len_q;

	logic                 out_valid_q, popped_q;
	logic [STAT_W-1:0]    status_q;
	logic [FRAME_W-1:0]   frames_q;
	logic [LIM_W-1:0]     bytes_q, remain_q;

	logic                 accept;
	logic [LEN_BITS-1:0]  len, cnt, front_left;
	logic [AW-1:0]        head_next, tail_next;
	logic                 full;

	status_t              st_n;
	logic [CNTW-1:0]      count_n;
	logic [LEN_BITS-1:0]  offset_n, total_n, front_len_n, offset_sum, remain_n;
	logic [AW-1:0]        head_n, tail_n;
	logic                 wr_en, pop, fetch;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign cfg_ready = 1'b1;

	assign len        = LEN_BITS'(frame_length);
	assign cnt        = LEN_BITS'(consume_count);
	assign front_left = (count_q == '0) ? '0 : front_len_q - offset_q;
	assign head_next  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign tail_next  = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + AW'(1);
	assign full       = (CMPW'(count_q) >= CMPW'(frame_limit_q)) ||
		(count_q == CNTW'(DEPTH));
	assign offset_sum = offset_q + cnt;

	always_comb begin
		st_n        = STAT_OK;
		count_n     = count_q;
		offset_n    = offset_q;
		total_n     = total_q;
		front_len_n = front_len_q;
		head_n      = head_q;
		tail_n      = tail_q;
		wr_en       = 1'b0;
		pop         = 1'b0;
		case (op_t'(operation))
			OP_ENQUEUE: begin
				if (len == '0) begin
					st_n = STAT_INVALID;
				end else if (frame_limit_q == '0 || byte_limit_q == '0 ||
						CW'(len) > CW'(byte_limit_q)) begin
					st_n = STAT_TOO_LARGE;
				end else if (full || CW'(total_q) > CW'(byte_limit_q) - CW'(len)) begin
					st_n = STAT_OVERFLOW;
				end else begin
					wr_en   = 1'b1;
					tail_n  = tail_next;
					count_n = count_q + CNTW'(1);
					total_n = total_q + len;
					if (count_q == '0) begin
						front_len_n = len;
					end
				end
			end
			OP_CONSUME: begin
				if (count_q == '0 || cnt == '0 || cnt > front_left) begin
					st_n = STAT_CONSUME_REJ;
				end else begin
					total_n  = total_q - cnt;
					offset_n = offset_sum;
					if (offset_sum == front_len_q) begin
						pop      = 1'b1;
						head_n   = head_next;
						count_n  = count_q - CNTW'(1);
						offset_n = '0;
					end
				end
			end
			OP_CLEAR: begin
				head_n   = '0;
				tail_n   = '0;
				count_n  = '0;
				offset_n = '0;
				total_n  = '0;
			end
			default: begin
			end
		endcase
		fetch    = pop && (count_n != '0);
		remain_n = (count_n == '0) ? '0 : front_len_n - offset_n;
	end

	// A pop never writes, so the read at the next head never meets a same-cycle write.
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			ring_q[tail_q] <= len;
		end
		rd_data_q <= ring_q[head_next];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q <= FRAME_LIMIT_RST;
			byte_limit_q  <= BYTE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_FRAME_LIMIT: frame_limit_q <= cfg_data[FRAME_W-1:0];
				REG_BYTE_LIMIT:  byte_limit_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			offset_q    <= '0;
			total_q     <= '0;
			front_len_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result, or drop the current one once it is taken
			if (state_q == ST_FETCH || (accept && !fetch)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						head_q      <= head_n;
						tail_q      <= tail_n;
						count_q     <= count_n;
						offset_q    <= offset_n;
						total_q     <= total_n;
						front_len_q <= front_len_n;
						if (fetch) begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					// new front length arrives from the ring
					front_len_q <= rd_data_q;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH) begin
			status_q <= STAT_OK;
			frames_q <= FRAME_W'(count_q);
			bytes_q  <= LIM_W'(total_q);
			remain_q <= LIM_W'(rd_data_q);
			popped_q <= 1'b1;
		end else if (accept && !fetch) begin
			status_q <= st_n;
			frames_q <= FRAME_W'(count_n);
			bytes_q  <= LIM_W'(total_n);
			remain_q <= LIM_W'(remain_n);
			popped_q <= pop;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign frames_held     = frames_q;
	assign bytes_held      = bytes_q;
	assign front_remaining = remain_q;
	assign front_popped    = popped_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(DEPTH))
		else $error("frame count above ring depth");

	a_fetch_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FETCH |=> state_q == ST_IDLE && out_valid_q)
		else $error("front fetch did not finish in one cycle");

	a_empty_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> total_q == '0 && offset_q == '0)
		else $error("empty queue holds bytes");

	a_front_offset: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && state_q == ST_IDLE |-> offset_q < front_len_q)
		else $error("front offset reached front length without pop");

	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && popped_q |-> status_q == STAT_OK)
		else $error("pop reported on a rejected request");

endmodule

@@ dv/tb_frame_queue_byte_budget.sv @@
// Self-checking bench for frame_queue_byte_budget: directed and random queue requests,
// scored field by field against an in-bench model of the frame queue and its budgets.
// Depends on fqbb_pkg and the frame_queue_byte_budget RTL.
module tb_frame_queue_byte_budget;
	timeunit 1ns;
	timeprecision 1ps;
	import fqbb_pkg::*;

	localparam int CLK_HALF       = 10;
	localparam int RESET_CYCLES   = 7;
	localparam int DEPTH          = DEPTH_DEF;
	localparam int BURST_CYCLES   = 150;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		op_t              op;
		logic [LIM_W-1:0] length;
		logic [LIM_W-1:0] count;
	} frame_req_t;

	typedef struct {
		status_t            status;
		logic [FRAME_W-1:0] frames;
		logic [LIM_W-1:0]   bytes;
		logic [LIM_W-1:0]   front;
		logic               popped;
	} occupancy_t;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               in_valid      = 1'b0;
	logic               in_stall;
	logic [OP_W-1:0]    operation     = '0;
	logic [LIM_W-1:0]   frame_length  = '0;
	logic [LIM_W-1:0]   consume_count = '0;
	logic               out_valid;
	logic               out_stall     = 1'b0;
	logic [STAT_W-1:0]  status;
	logic [FRAME_W-1:0] frames_held;
	logic [LIM_W-1:0]   bytes_held;
	logic [LIM_W-1:0]   front_remaining;
	logic               front_popped;
	logic               cfg_valid     = 1'b0;
	logic               cfg_ready;
	logic [CFG_W-1:0]   cfg_index     = '0;
	logic [LIM_W-1:0]   cfg_data      = '0;

	frame_queue_byte_budget dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.frame_length    (frame_length),
		.consume_count   (consume_count),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.frames_held     (frames_held),
		.bytes_held      (bytes_held),
		.front_remaining (front_remaining),
		.front_popped    (front_popped),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// Queue model state and its copy of the limit registers
	logic [LIM_W-1:0]   ring_len [DEPTH];
	int unsigned        head_slot  = 0;
	int unsigned        tail_slot  = 0;
	int unsigned        frame_cnt  = 0;
	logic [LIM_W-1:0]   front_sent = '0;
	logic [LIM_W-1:0]   byte_cnt   = '0;
	logic [FRAME_W-1:0] lim_frames = FRAME_LIMIT_RST;
	logic [LIM_W-1:0]   lim_bytes  = BYTE_LIMIT_RST;

	// Remaining bytes per queued frame as the request generator expects them
	int unsigned plan_left[$];
	int unsigned plan_bytes = 0;

	frame_req_t  pending_reqs[$];
	frame_req_t  on_wire;
	occupancy_t  occupancy_q[$];

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	logic        burst_arm      = 1'b0;
	logic        burst_used     = 1'b0;
	int unsigned burst_left     = 0;
	int unsigned idle_cycles    = 0;

	int mismatches   = 0;
	int reqs_sent    = 0;
	int results_seen = 0;
	int reg_writes   = 0;
	int status_seen[5];

	function automatic logic [LIM_W-1:0] front_unsent();
		if (frame_cnt == 0)
			return '0;
		return ring_len[head_slot] - front_sent;
	endfunction

	function automatic occupancy_t apply_request(frame_req_t rq);
		occupancy_t  rep;
		int unsigned cap;
		int unsigned len;
		int unsigned lim;
		rep.status = STAT_OK;
		rep.popped = 1'b0;
		len = rq.length;
		lim = lim_bytes;
		cap = (lim_frames < DEPTH) ? lim_frames : DEPTH;
		case (rq.op)
		OP_ENQUEUE: begin
			if (len == 0)
				rep.status = STAT_INVALID;
			else if (lim_frames == 0 || lim == 0 || len > lim)
				rep.status = STAT_TOO_LARGE;
			else if (frame_cnt >= cap || byte_cnt > lim - len)
				rep.status = STAT_OVERFLOW;
			else begin
				ring_len[tail_slot] = rq.length;
				tail_slot = (tail_slot + 1) % DEPTH;
				frame_cnt++;
				byte_cnt = byte_cnt + rq.length;
			end
		end
		OP_CONSUME: begin
			if (frame_cnt == 0 || rq.count == 0 || rq.count > front_unsent())
				rep.status = STAT_CONSUME_REJ;
			else begin
				front_sent = front_sent + rq.count;
				byte_cnt = byte_cnt - rq.count;
				if (front_sent == ring_len[head_slot]) begin
					head_slot = (head_slot + 1) % DEPTH;
					frame_cnt--;
					front_sent = '0;
					rep.popped = 1'b1;
				end
			end
		end
		OP_CLEAR: begin
			head_slot = 0;
			tail_slot = 0;
			frame_cnt = 0;
			front_sent = '0;
			byte_cnt = '0;
		end
		default: ;
		endcase
		rep.frames = FRAME_W'(frame_cnt);
		rep.bytes = byte_cnt;
		rep.front = front_unsent();
		return rep;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Request driver: predict on acceptance, then offer the next pending request or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				occupancy_q.insert(occupancy_q.size(), apply_request(on_wire));
				reqs_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_wire = pending_reqs[0];
					pending_reqs.delete(0);
					in_valid <= 1'b1;
					operation <= on_wire.op;
					frame_length <= on_wire.length;
					consume_count <= on_wire.count;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result side: random stalls, plus one long hold-off once armed
	always @(posedge clk) begin
		if (burst_left != 0) begin
			out_stall <= 1'b1;
			burst_left--;
		end else if (burst_arm && !burst_used) begin
			burst_used = 1'b1;
			burst_left = BURST_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin : result_monitor
		occupancy_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (occupancy_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, got status %0d frames %0d bytes %0d",
					$time, status, frames_held, bytes_held);
			end else begin
				want = occupancy_q[0];
				occupancy_q.delete(0);
				check_field("status", want.status, status);
				check_field("frames_held", want.frames, frames_held);
				check_field("bytes_held", want.bytes, bytes_held);
				check_field("front_remaining", want.front, front_remaining);
				check_field("front_popped", want.popped, front_popped);
				status_seen[want.status]++;
				results_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no handshake for %0d cycles", $time, idle_cycles);
			$display("FAIL");
			$finish;
		end
	end

	// Append a request and advance the generator's view of the queue
	task automatic queue_req(input op_t op, input int unsigned length, input int unsigned count);
		frame_req_t  rq;
		int unsigned cap;
		rq.op = op;
		rq.length = LIM_W'(length);
		rq.count = LIM_W'(count);
		cap = (lim_frames < DEPTH) ? lim_frames : DEPTH;
		case (op)
		OP_ENQUEUE: begin
			if (rq.length != 0 && rq.length <= lim_bytes && plan_left.size() < cap
					&& plan_bytes + rq.length <= lim_bytes) begin
				plan_left.insert(plan_left.size(), rq.length);
				plan_bytes += rq.length;
			end
		end
		OP_CONSUME: begin
			if (plan_left.size() != 0 && rq.count != 0 && rq.count <= plan_left[0]) begin
				plan_left[0] -= rq.count;
				plan_bytes -= rq.count;
				if (plan_left[0] == 0)
					plan_left.delete(0);
			end
		end
		OP_CLEAR: begin
			plan_left.delete();
			plan_bytes = 0;
		end
		default: ;
		endcase
		pending_reqs.insert(pending_reqs.size(), rq);
	endtask

	// Mostly well-formed enqueue/consume traffic, some clears and malformed requests
	task automatic random_req();
		int unsigned pick;
		int unsigned len;
		int unsigned cnt;
		int unsigned room;
		pick = $urandom_range(99);
		len = $urandom & 32'hFFFFF;
		cnt = $urandom & 32'hFFFFF;
		if (pick < 45 || (plan_left.size() == 0 && pick < 85)) begin
			room = (lim_bytes > plan_bytes) ? lim_bytes - plan_bytes : 0;
			pick = $urandom_range(99);
			if (pick < 65)
				len = $urandom_range(1, 1500);
			else if (pick < 75 && room != 0)
				len = room;
			else if (pick < 80)
				len = room + 1;
			else if (pick < 85)
				len = lim_bytes;
			else if (pick < 90)
				len = 0;
			queue_req(OP_ENQUEUE, len, cnt);
		end else if (pick < 85) begin
			pick = $urandom_range(99);
			if (pick < 50)
				cnt = plan_left[0];
			else if (pick < 85)
				cnt = $urandom_range(1, plan_left[0]);
			else if (pick < 90)
				cnt = 0;
			else if (pick < 95)
				cnt = plan_left[0] + 1;
			queue_req(OP_CONSUME, len, cnt);
		end else if (pick < 89) begin
			queue_req(OP_CLEAR, len, cnt);
		end else if (pick < 91) begin
			queue_req(OP_NOP, len, cnt);
		end else begin
			queue_req(op_t'($urandom_range(3)), len, cnt);
		end
	endtask

	// Sample on the falling edge so the driver and monitor have finished their updates
	task automatic settle();
		while (pending_reqs.size() != 0 || in_valid || occupancy_q.size() != 0)
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [LIM_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_FRAME_LIMIT)
			lim_frames = value[FRAME_W-1:0];
		else
			lim_bytes = value;
		reg_writes++;
	endtask

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++)
			random_req();
	endtask

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Budget edges, consume rejections, pops and clear at the reset limits
		queue_req(OP_CONSUME, 0, 5);
		queue_req(OP_ENQUEUE, 0, 0);
		queue_req(OP_ENQUEUE, 65537, 0);
		queue_req(OP_ENQUEUE, 20'hFFFFF, 20'hFFFFF);
		queue_req(OP_ENQUEUE, 65536, 0);
		queue_req(OP_ENQUEUE, 1, 0);
		queue_req(OP_CONSUME, 0, 0);
		queue_req(OP_CONSUME, 0, 65537);
		queue_req(OP_CONSUME, 0, 65535);
		queue_req(OP_CONSUME, 0, 2);
		queue_req(OP_CONSUME, 0, 1);
		queue_req(OP_NOP, 20'hFFFFF, 20'hFFFFF);
		queue_req(OP_ENQUEUE, 100, 0);
		queue_req(OP_ENQUEUE, 200, 0);
		queue_req(OP_CONSUME, 0, 100);
		queue_req(OP_CONSUME, 0, 200);
		queue_req(OP_ENQUEUE, 300, 0);
		queue_req(OP_ENQUEUE, 400, 0);
		queue_req(OP_CLEAR, 0, 0);
		queue_req(OP_CONSUME, 0, 1);
		queue_req(OP_ENQUEUE, 1, 0);
		queue_req(OP_CONSUME, 0, 1);
		random_phase(150);
		settle();

		// Frame limit above depth, widest byte budget; sender mostly idle
		write_reg(REG_FRAME_LIMIT, 31);
		write_reg(REG_BYTE_LIMIT, 20'hFFFFF);
		send_idle_pct = 75;
		random_phase(150);
		// Leave the queue deep so the smaller frame limit starts below occupancy
		for (int i = 0; i < DEPTH; i++)
			queue_req(OP_ENQUEUE, $urandom_range(1, 200), 0);
		settle();

		// Upper data bits fall outside the frame limit register
		write_reg(REG_FRAME_LIMIT, 20'hFFFE3);
		write_reg(REG_BYTE_LIMIT, 5000);
		send_idle_pct = 0;
		recv_stall_pct = 75;
		random_phase(150);
		settle();

		send_idle_pct = 34;
		recv_stall_pct = 34;
		write_reg(REG_FRAME_LIMIT, 0);
		write_reg(REG_BYTE_LIMIT, 1);
		random_phase(40);
		settle();
		write_reg(REG_FRAME_LIMIT, 8);
		write_reg(REG_BYTE_LIMIT, 0);
		random_phase(40);
		settle();
		write_reg(REG_FRAME_LIMIT, 1);
		write_reg(REG_BYTE_LIMIT, 1);
		random_phase(40);
		settle();

		// Back to reset limits; hold the result side off while requests keep coming
		write_reg(REG_FRAME_LIMIT, 16);
		write_reg(REG_BYTE_LIMIT, 65536);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		burst_arm = 1'b1;
		random_phase(150);
		settle();

		send_idle_pct = 34;
		recv_stall_pct = 34;
		random_phase(30);
		settle();
		repeat (5) @(posedge clk);

		$display("Sent %0d requests, checked %0d results, made %0d limit writes",
			reqs_sent, results_seen, reg_writes);
		$display("Status mix: ok %0d, invalid %0d, too large %0d, overflow %0d, rejected %0d",
			status_seen[STAT_OK], status_seen[STAT_INVALID], status_seen[STAT_TOO_LARGE],
			status_seen[STAT_OVERFLOW], status_seen[STAT_CONSUME_REJ]);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
